/* rtl/pzu_pkg.sv */
`timescale 1ns / 1ps
// Package for the 18-bit polynomial unpacker with byte-load fault injection.
// Holds constants, register indexes, fault codes, controller states and the
// command and status structs shared by the controller and the datapath.
package pzu_pkg;

   // Default polynomial length; the top level takes it as a parameter.
   localparam int NUM_COEFFS_DEF = 256;

   // Offset subtracted from: coefficient = GAMMA - raw field.
   localparam int GAMMA = 131072;

   // FNV-1a constants.
   localparam logic [31:0] HASH_INIT  = 32'h811c_9dc5;
   localparam logic [31:0] HASH_PRIME = 32'h0100_0193;

   // Last byte position of a nine-byte group.
   localparam logic [3:0] GROUP_LAST_POS = 4'd8;

   // Register reset values.
   localparam logic [1:0] FAULT_MODE_RST  = 2'd0;
   localparam logic [7:0] TARGET_COEF_RST = 8'd17;
   localparam logic [1:0] TARGET_LOAD_RST = 2'd1;
   localparam logic [7:0] STALE_VALUE_RST = 8'd90;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_FAULT_MODE  = 2'd0;
   localparam logic [1:0] CSR_TARGET_COEF = 2'd1;
   localparam logic [1:0] CSR_TARGET_LOAD = 2'd2;
   localparam logic [1:0] CSR_STALE_VALUE = 2'd3;

   // Fault modes; any other code means normal unpacking.
   localparam logic [1:0] FAULT_ZERO  = 2'd1;
   localparam logic [1:0] FAULT_STALE = 2'd2;

   // Byte selectors; any other selector, two or three, picks the third byte.
   localparam logic [1:0] LOAD_FIRST  = 2'd0;
   localparam logic [1:0] LOAD_SECOND = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND1,
      ST_ROUND2,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take_byte;
      logic round1;
      logic round2;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic coef_byte;
   } status_type;

endpackage

/* rtl/polyz_unpack_with_load_fault_unit.sv */
`timescale 1ns / 1ps
// Top level of the 18-bit polynomial unpacker with byte-load fault injection.
// Instantiates pzu_ctrl and pzu_datapath; uses pzu_pkg.

// The unit takes a packed polynomial one byte per item, nine bytes for every
// four 18-bit little-endian fields, and returns one coefficient item each
// time a byte completes a field. A byte that only gets held is stored and the
// unit stays ready for the next byte. A byte that completes a coefficient
// occupies the unit through its intake, two FNV-1a rounds that share a single
// 32 by 32 multiplier, and a step that moves the finished coefficient into
// the result register, which waits while that register is still full. Because
// the result sits in its own register, the unit takes the following bytes
// while a coefficient waits for the consumer. Each coefficient is GAMMA minus
// its raw field; the digest is reported on the last coefficient of the
// polynomial and is zero on all others, after which the byte position, the
// coefficient count and the hash restart. The configuration registers select
// a fault that replaces one byte of one target coefficient with zero or with
// a stale byte; they should be written only while the unit is idle.
module polyz_unpack_with_load_fault_unit #(
   parameter int NUM_COEFFS = pzu_pkg::NUM_COEFFS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // Configuration write port.
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata,
   // Packed byte input.
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_packed_byte,
   // Coefficient output.
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [18:0] rsp_coefficient,
   output logic [7:0]         rsp_coefficient_index,
   output logic               rsp_fault_applied,
   output logic               rsp_last,
   output logic [31:0]        rsp_digest
);

   pzu_pkg::cmd_type    cmd;
   pzu_pkg::status_type status;

   // The controller decides when bytes are taken and when hash rounds run.
   pzu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the registers, the byte assembly and the hash.
   pzu_datapath #(
      .NUM_COEFFS (NUM_COEFFS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_packed_byte       (req_packed_byte),
      .rsp_coefficient       (rsp_coefficient),
      .rsp_coefficient_index (rsp_coefficient_index),
      .rsp_fault_applied     (rsp_fault_applied),
      .rsp_last              (rsp_last),
      .rsp_digest            (rsp_digest)
   );

endmodule

/* rtl/pzu_ctrl.sv */
`timescale 1ns / 1ps
// Controller for the polynomial unpacker: sequences byte intake, the two
// hash rounds and the hand-off to the result register. Uses pzu_pkg.
module pzu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  pzu_pkg::status_type status,
   output pzu_pkg::cmd_type    cmd
);

   pzu_pkg::state_type state_ff;
   pzu_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pzu_pkg::ST_IDLE: begin
            if (req_valid && status.coef_byte) begin
               state_in = pzu_pkg::ST_ROUND1;
            end
         end
         pzu_pkg::ST_ROUND1: begin
            state_in = pzu_pkg::ST_ROUND2;
         end
         pzu_pkg::ST_ROUND2: begin
            state_in = pzu_pkg::ST_EMIT;
         end
         pzu_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = pzu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pzu_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         pzu_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.take_byte = req_valid;
         end
         pzu_pkg::ST_ROUND1: begin
            cmd.round1 = 1'b1;
         end
         pzu_pkg::ST_ROUND2: begin
            cmd.round2 = 1'b1;
         end
         pzu_pkg::ST_EMIT: begin
            cmd.load_out = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // The result register stays full until the consumer takes the item.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pzu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/pzu_datapath.sv */
`timescale 1ns / 1ps
// Datapath for the polynomial unpacker: configuration registers, byte
// assembly with fault replacement, the shared hash multiplier and the
// result register. Uses pzu_pkg.
module pzu_datapath #(
   parameter int NUM_COEFFS = pzu_pkg::NUM_COEFFS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  pzu_pkg::cmd_type    cmd,
   output pzu_pkg::status_type status,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   input  logic [7:0]          req_packed_byte,
   output logic signed [18:0]  rsp_coefficient,
   output logic [7:0]          rsp_coefficient_index,
   output logic                rsp_fault_applied,
   output logic                rsp_last,
   output logic [31:0]         rsp_digest
);

   localparam int CNT_W = $clog2(NUM_COEFFS);
   localparam int IDX_W = (CNT_W > 8) ? CNT_W : 8;

   // Configuration registers.
   logic [1:0] fault_mode_ff,  fault_mode_in;
   logic [7:0] target_coef_ff, target_coef_in;
   logic [1:0] target_load_ff, target_load_in;
   logic [7:0] stale_value_ff, stale_value_in;

   // Stream state.
   logic [3:0]       pos_ff, pos_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       held0_ff, held0_in;
   logic [7:0]       held1_ff, held1_in;
   logic [31:0]      hash_ff, hash_in;

   // Coefficient at work.
   logic [31:0] work_word_ff, work_word_in;
   logic [7:0]  work_index_ff, work_index_in;
   logic        work_fault_ff, work_fault_in;
   logic        work_last_ff, work_last_in;
   logic [31:0] work_digest_ff, work_digest_in;

   // Result register.
   logic signed [18:0] rsp_coef_ff;
   logic [7:0]         rsp_index_ff;
   logic               rsp_fault_ff;
   logic               rsp_last_ff;
   logic [31:0]        rsp_digest_ff;

   logic             coef_byte;
   logic             is_last;
   logic [IDX_W:0]   tgt_ext;
   logic [IDX_W-1:0] eff_tgt;
   logic [IDX_W-1:0] cnt_ext;
   logic             fault_on;
   logic             fault_hit;
   logic [7:0]       repl_byte;
   logic [7:0]       b0, b1, b2;
   logic [1:0]       slot;
   logic [23:0]      field_bits;
   logic [17:0]      raw;
   logic [31:0]      coef_word;
   logic [31:0]      mix;
   logic [31:0]      prod;

   // A byte at an even position from two on completes a coefficient.
   assign coef_byte        = (pos_ff >= 4'd2) && !pos_ff[0];
   assign status.coef_byte = coef_byte;

   assign is_last = (cnt_ff == CNT_W'(NUM_COEFFS - 1));

   // A target beyond the polynomial falls back to coefficient zero.
   assign tgt_ext = (IDX_W + 1)'(target_coef_ff);
   assign eff_tgt = (tgt_ext >= (IDX_W + 1)'(NUM_COEFFS)) ? '0 : tgt_ext[IDX_W-1:0];
   assign cnt_ext = IDX_W'(cnt_ff);

   assign fault_on  = (fault_mode_ff == pzu_pkg::FAULT_ZERO) ||
                      (fault_mode_ff == pzu_pkg::FAULT_STALE);
   assign fault_hit = fault_on && (cnt_ext == eff_tgt);
   assign repl_byte = (fault_mode_ff == pzu_pkg::FAULT_ZERO) ? 8'd0 : stale_value_ff;

   always_comb begin
      b0 = held0_ff;
      b1 = held1_ff;
      b2 = req_packed_byte;
      if (fault_hit) begin
         if (target_load_ff == pzu_pkg::LOAD_FIRST) begin
            b0 = repl_byte;
         end else if (target_load_ff == pzu_pkg::LOAD_SECOND) begin
            b1 = repl_byte;
         end else begin
            b2 = repl_byte;
         end
      end
   end

   // Field slot within the group: positions 2, 4, 6, 8 give slots 0 to 3.
   assign slot       = pos_ff[2:1] - 2'd1;
   assign field_bits = {b2, b1, b0} >> {slot, 1'b0};
   assign raw        = field_bits[17:0];
   assign coef_word  = 32'(pzu_pkg::GAMMA) - 32'(raw);

   // One multiplier serves both hash rounds.
   assign mix  = hash_ff ^ (cmd.round2 ? {16'd0, work_word_ff[31:16]} : work_word_ff);
   assign prod = mix * pzu_pkg::HASH_PRIME;

   always_comb begin
      fault_mode_in  = fault_mode_ff;
      target_coef_in = target_coef_ff;
      target_load_in = target_load_ff;
      stale_value_in = stale_value_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            pzu_pkg::CSR_FAULT_MODE:  fault_mode_in  = csr_wdata[1:0];
            pzu_pkg::CSR_TARGET_COEF: target_coef_in = csr_wdata;
            pzu_pkg::CSR_TARGET_LOAD: target_load_in = csr_wdata[1:0];
            pzu_pkg::CSR_STALE_VALUE: stale_value_in = csr_wdata;
            default:                  fault_mode_in  = fault_mode_ff;
         endcase
      end
   end

   always_comb begin
      pos_in         = pos_ff;
      cnt_in         = cnt_ff;
      held0_in       = held0_ff;
      held1_in       = held1_ff;
      hash_in        = hash_ff;
      work_word_in   = work_word_ff;
      work_index_in  = work_index_ff;
      work_fault_in  = work_fault_ff;
      work_last_in   = work_last_ff;
      work_digest_in = work_digest_ff;

      if (cmd.take_byte) begin
         if (!coef_byte) begin
            if (pos_ff[0]) begin
               held1_in = req_packed_byte;
            end else begin
               held0_in = req_packed_byte;
            end
            pos_in = pos_ff + 4'd1;
         end else begin
            work_word_in  = coef_word;
            work_index_in = cnt_ext[7:0];
            work_fault_in = fault_hit;
            work_last_in  = is_last;
            if (is_last) begin
               pos_in = '0;
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (pos_ff >= pzu_pkg::GROUP_LAST_POS) begin
                  pos_in = '0;
               end else begin
                  held0_in = req_packed_byte;
                  pos_in   = pos_ff + 4'd1;
               end
            end
         end
      end

      if (cmd.round1) begin
         hash_in = prod;
      end

      if (cmd.round2) begin
         hash_in        = work_last_ff ? pzu_pkg::HASH_INIT : prod;
         work_digest_in = work_last_ff ? prod : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_mode_ff  <= pzu_pkg::FAULT_MODE_RST;
         target_coef_ff <= pzu_pkg::TARGET_COEF_RST;
         target_load_ff <= pzu_pkg::TARGET_LOAD_RST;
         stale_value_ff <= pzu_pkg::STALE_VALUE_RST;
         pos_ff         <= '0;
         cnt_ff         <= '0;
         hash_ff        <= pzu_pkg::HASH_INIT;
      end else begin
         fault_mode_ff  <= fault_mode_in;
         target_coef_ff <= target_coef_in;
         target_load_ff <= target_load_in;
         stale_value_ff <= stale_value_in;
         pos_ff         <= pos_in;
         cnt_ff         <= cnt_in;
         hash_ff        <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      held0_ff       <= held0_in;
      held1_ff       <= held1_in;
      work_word_ff   <= work_word_in;
      work_index_ff  <= work_index_in;
      work_fault_ff  <= work_fault_in;
      work_last_ff   <= work_last_in;
      work_digest_ff <= work_digest_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_coef_ff   <= $signed(work_word_ff[18:0]);
         rsp_index_ff  <= work_index_ff;
         rsp_fault_ff  <= work_fault_ff;
         rsp_last_ff   <= work_last_ff;
         rsp_digest_ff <= work_digest_ff;
      end
   end

   assign rsp_coefficient       = rsp_coef_ff;
   assign rsp_coefficient_index = rsp_index_ff;
   assign rsp_fault_applied     = rsp_fault_ff;
   assign rsp_last              = rsp_last_ff;
   assign rsp_digest            = rsp_digest_ff;

endmodule

/* rtl/pzu_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the polynomial unpacker, bound to the top level.
// Uses pzu_pkg for the default polynomial length.
module pzu_checker #(
   parameter int NUM_COEFFS = pzu_pkg::NUM_COEFFS_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_coefficient_index,
   input logic        rsp_last,
   input logic [31:0] rsp_digest
);

   localparam logic [7:0] LAST_INDEX = 8'(NUM_COEFFS - 1);

   // A result is never shown right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // Only the final coefficient carries a digest.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_digest == 32'd0)
      else $error("digest nonzero on a coefficient that is not last");

   // The final coefficient has the last index of the polynomial.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_coefficient_index == LAST_INDEX)
      else $error("last flag on the wrong coefficient index");

endmodule

bind polyz_unpack_with_load_fault_unit pzu_checker #(
   .NUM_COEFFS (NUM_COEFFS)
) u_pzu_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_coefficient_index (rsp_coefficient_index),
   .rsp_last              (rsp_last),
   .rsp_digest            (rsp_digest)
);
